### rtl/core/gst_pkg.sv
// Shared constants, tables and helper functions for the GOST 64-bit block cipher core.
package gst_pkg;

  localparam int unsigned NumRounds = 32;
  localparam int unsigned NumKeyRegs = 4;
  localparam int unsigned KeyRegWidth = 64;
  localparam int unsigned HalfWidth = 32;
  localparam int unsigned BlockWidth = 64;
  localparam int unsigned RotAmt = 11;
  localparam int unsigned CfgIdxWidth = 2;

  typedef logic [HalfWidth-1:0] half_t;
  typedef logic [2:0] key_num_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxWidth-1:0] {
    CfgKey0 = 2'd0,
    CfgKey1 = 2'd1,
    CfgKey2 = 2'd2,
    CfgKey3 = 2'd3
  } cfg_idx_e;

  // Direction codes carried on the opcode field.
  localparam logic OpEncrypt = 1'b0;
  localparam logic OpDecrypt = 1'b1;

  typedef logic [3:0] sbox_row_t [16];

  localparam sbox_row_t Sbox [8] = '{
    '{4'd12, 4'd4,  4'd6,  4'd2,  4'd10, 4'd5,  4'd11, 4'd9,
      4'd14, 4'd8,  4'd13, 4'd7,  4'd0,  4'd3,  4'd15, 4'd1},
    '{4'd6,  4'd8,  4'd2,  4'd3,  4'd9,  4'd10, 4'd5,  4'd12,
      4'd1,  4'd14, 4'd4,  4'd7,  4'd11, 4'd13, 4'd0,  4'd15},
    '{4'd11, 4'd3,  4'd5,  4'd8,  4'd2,  4'd15, 4'd10, 4'd13,
      4'd14, 4'd1,  4'd7,  4'd4,  4'd12, 4'd9,  4'd6,  4'd0},
    '{4'd12, 4'd8,  4'd2,  4'd1,  4'd13, 4'd4,  4'd15, 4'd6,
      4'd7,  4'd0,  4'd10, 4'd5,  4'd3,  4'd14, 4'd9,  4'd11},
    '{4'd7,  4'd15, 4'd5,  4'd10, 4'd8,  4'd1,  4'd6,  4'd13,
      4'd0,  4'd9,  4'd3,  4'd14, 4'd11, 4'd4,  4'd2,  4'd12},
    '{4'd5,  4'd13, 4'd15, 4'd6,  4'd9,  4'd2,  4'd12, 4'd10,
      4'd11, 4'd7,  4'd8,  4'd1,  4'd4,  4'd3,  4'd14, 4'd0},
    '{4'd8,  4'd14, 4'd2,  4'd5,  4'd6,  4'd9,  4'd1,  4'd12,
      4'd15, 4'd4,  4'd11, 4'd0,  4'd13, 4'd10, 4'd3,  4'd7},
    '{4'd1,  4'd7,  4'd14, 4'd13, 4'd0,  4'd5,  4'd8,  4'd3,
      4'd4,  4'd15, 4'd10, 4'd6,  4'd9,  4'd12, 4'd11, 4'd2}
  };

  // Substitute each nibble through its own S-box, then rotate left.
  function automatic half_t sub_rot(input half_t x);
    half_t y;
    for (int i = 0; i < 8; i++) begin
      y[4*i +: 4] = Sbox[i][x[4*i +: 4]];
    end
    return {y[HalfWidth-RotAmt-1:0], y[HalfWidth-1:HalfWidth-RotAmt]};
  endfunction

  // Zero-based subkey number for an encryption round: 0..7 three times, then 7..0.
  function automatic key_num_t enc_key_num(input int unsigned rnd);
    key_num_t low;
    low = key_num_t'(rnd % 8);
    return (rnd < 24) ? low : (3'd7 - low);
  endfunction

  function automatic key_num_t key_num(input int unsigned rnd, input logic dec);
    return dec ? enc_key_num(NumRounds - 1 - rnd) : enc_key_num(rnd);
  endfunction

endpackage

### rtl/core/gst_stage.sv
// One Feistel round with its pipeline register and valid bit.
module gst_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  output logic           ready_o,
  input  gst_pkg::half_t l_i,
  input  gst_pkg::half_t r_i,
  input  logic           dec_i,
  input  gst_pkg::half_t subkey_i,
  output logic           valid_o,
  input  logic           ready_i,
  output gst_pkg::half_t a_o,
  output gst_pkg::half_t b_o,
  output logic           dec_o
);
  import gst_pkg::*;

  logic  valid_q;
  half_t a_q, b_q;
  logic  dec_q;
  half_t t_d;

  // The stage takes a new beat when it is empty or its content moves on.
  assign ready_o = !valid_q || ready_i;
  assign t_d     = l_i ^ sub_rot(r_i + subkey_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // a holds the old right half, b the new one.
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      a_q   <= r_i;
      b_q   <= t_d;
      dec_q <= dec_i;
    end
  end

  assign valid_o = valid_q;
  assign a_o     = a_q;
  assign b_o     = b_q;
  assign dec_o   = dec_q;

endmodule

### rtl/core/gost_block_cipher_64_core.sv
// Top level of the GOST 28147-89 (param-Z S-boxes) 64-bit block cipher core.
//
// Input channel: in_valid_i / in_ready_o carry one beat holding a 64-bit block
// (byte 0 in the top bits) and opcode_i (0 encrypt, 1 decrypt). Output channel:
// out_valid_o / out_ready_i carry the processed block on block_out_o.
// The key is loaded through the write port: cfg_we_i, cfg_idx_i selects one of
// four 64-bit key words, cfg_wdata_i holds the data. Load it only while idle.
// Each of the 32 rounds has its own pipeline register; a block passes all 32
// registers on its way out, and one block is taken per cycle unless stalled.
// Every stage has a valid bit; when the receiver stalls, the pipeline fills
// bubbles ahead of the held result and keeps accepting beats until every
// stage holds one, after which in_ready_o drops. Nothing is lost or repeated.
// Reset clears all valid bits and sets the key to zero.
module gost_block_cipher_64_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                opcode_i,
  input  logic [gst_pkg::BlockWidth-1:0]      block_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [gst_pkg::BlockWidth-1:0]      block_out_o,
  input  logic                                cfg_we_i,
  input  logic [gst_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [gst_pkg::KeyRegWidth-1:0]     cfg_wdata_i
);
  import gst_pkg::*;

  logic [KeyRegWidth-1:0] key_q [NumKeyRegs];

  logic  valid_s [NumRounds+1];
  logic  ready_s [NumRounds+1];
  half_t l_s     [NumRounds+1];
  half_t r_s     [NumRounds+1];
  logic  dec_s   [NumRounds+1];
  half_t a_s     [NumRounds];
  half_t b_s     [NumRounds];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumKeyRegs; i++) begin
        key_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CfgKey0: key_q[0] <= cfg_wdata_i;
        CfgKey1: key_q[1] <= cfg_wdata_i;
        CfgKey2: key_q[2] <= cfg_wdata_i;
        CfgKey3: key_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign valid_s[0] = in_valid_i;
  assign in_ready_o = ready_s[0];
  assign l_s[0]     = block_in_i[BlockWidth-1:HalfWidth];
  assign r_s[0]     = block_in_i[HalfWidth-1:0];
  assign dec_s[0]   = (opcode_i == OpDecrypt);

  for (genvar g = 0; g < NumRounds; g++) begin : g_round
    localparam key_num_t EncKn = key_num(g, 1'b0);
    localparam key_num_t DecKn = key_num(g, 1'b1);

    key_num_t kn;
    logic [KeyRegWidth-1:0] kw;
    half_t subkey;

    assign kn     = dec_s[g] ? DecKn : EncKn;
    assign kw     = key_q[kn[2:1]];
    // Odd subkey numbers sit in the low half of a key word.
    assign subkey = kn[0] ? kw[HalfWidth-1:0] : kw[KeyRegWidth-1:HalfWidth];

    gst_stage u_stage (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .valid_i  (valid_s[g]),
      .ready_o  (ready_s[g]),
      .l_i      (l_s[g]),
      .r_i      (r_s[g]),
      .dec_i    (dec_s[g]),
      .subkey_i (subkey),
      .valid_o  (valid_s[g+1]),
      .ready_i  (ready_s[g+1]),
      .a_o      (a_s[g]),
      .b_o      (b_s[g]),
      .dec_o    (dec_s[g+1])
    );

    // Halves swap between rounds.
    assign l_s[g+1] = a_s[g];
    assign r_s[g+1] = b_s[g];
  end

  assign ready_s[NumRounds] = out_ready_i;
  assign out_valid_o        = valid_s[NumRounds];
  // The final round does not swap.
  assign block_out_o        = {r_s[NumRounds], l_s[NumRounds]};

endmodule
